// ----- hw/rtl/upc_pkg.sv -----
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types, constants and character helpers for the URL percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

    // Register map (byte addresses)
    localparam int unsigned AddrWidth = 3;
    localparam logic [AddrWidth-1:0] ADDR_MODE = 3'd0;

    // Mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Characters used by the codec
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    // Nibble value that marks a byte which is not a hex digit
    localparam logic [4:0] HEX_NONE = 5'd16;

    // Escape progress while decoding
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ONE  = 2'd1,
        PH_TWO  = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  value;
        logic        stopped;
    } t_esc;

    localparam t_esc ESC_CLEAR = '{phase: PH_IDLE, value: 8'h00, stopped: 1'b0};

    // One output word
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       string_end;
    } t_res;

    typedef t_res [2:0] t_res_set;

    // Letters, digits and the fixed safe punctuation pass through unencoded
    function automatic logic is_safe(input logic [7:0] b);
        logic hit;
        // : @ & = + $ - _ . ! * ' ( ) , / ? ~
        hit = b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                        8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24, 8'h2D, 8'h5F,
                        8'h2E, 8'h21, 8'h2A, 8'h27, 8'h28, 8'h29, 8'h2C, 8'h2F,
                        8'h3F, 8'h7E};
        return hit;
    endfunction

    // Value of a hex digit of either case, HEX_NONE for anything else
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        if (b inside {[8'h30:8'h39]}) begin
            v = 5'(b - CHAR_ZERO);
        end else if (b inside {[8'h61:8'h66]}) begin
            v = 5'(b - CHAR_LOWER_A + 8'd10);
        end else if (b inside {[8'h41:8'h46]}) begin
            v = 5'(b - CHAR_UPPER_A + 8'd10);
        end else begin
            v = HEX_NONE;
        end
        return v;
    endfunction

    // Lowercase hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = CHAR_ZERO + {4'h0, n};
        end else begin
            c = CHAR_LOWER_A + {4'h0, n} - 8'd10;
        end
        return c;
    endfunction

    // Fold one escape byte into the value until a non-hex byte freezes it
    function automatic t_esc take_digit(input t_esc e, input logic [7:0] b);
        t_esc       r;
        logic [4:0] v;
        r = e;
        v = hex_val(b);
        if (!e.stopped) begin
            if (v == HEX_NONE) begin
                r.stopped = 1'b1;
            end else begin
                r.value = {e.value[3:0], v[3:0]};
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/upc_step.sv -----
// ----------------------------------------------------------------------------
// upc_step
// Per-byte codec logic: turns one input byte and the escape state into up to
// three output words and the next escape state.
// ----------------------------------------------------------------------------
module upc_step import upc_pkg::*; (
    input  logic        i_mode,
    input  t_esc        i_esc,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic [1:0]  o_cnt,
    output t_res_set    o_res,
    output t_esc        o_esc_next
);

    t_esc       w_dig;
    logic       w_emit;
    logic [7:0] w_val;

    // Escape byte folded into the current value
    assign w_dig = take_digit(i_esc, i_byte);

    always_comb begin
        o_cnt      = 2'd0;
        o_res      = '0;
        o_esc_next = i_esc;
        w_emit     = 1'b0;
        w_val      = 8'h00;

        if (i_mode == MODE_ENCODE) begin
            // Pass safe bytes, expand the rest to three words
            if (is_safe(i_byte)) begin
                o_cnt    = 2'd1;
                o_res[0] = '{data: i_byte, run_end: 1'b1, string_end: i_last};
            end else begin
                o_cnt    = 2'd3;
                o_res[0] = '{data: CHAR_PERCENT, run_end: 1'b0, string_end: 1'b0};
                o_res[1] = '{data: hex_char(i_byte[7:4]), run_end: 1'b0,
                             string_end: 1'b0};
                o_res[2] = '{data: hex_char(i_byte[3:0]), run_end: 1'b1,
                             string_end: i_last};
            end
        end else begin
            case (i_esc.phase)
                PH_IDLE: begin
                    if (i_byte != CHAR_PERCENT) begin
                        o_cnt    = 2'd1;
                        o_res[0] = '{data: i_byte, run_end: 1'b1, string_end: i_last};
                    end else if (i_last) begin
                        // String ends right after the percent sign
                        w_emit = 1'b1;
                        w_val  = 8'h00;
                    end else begin
                        o_esc_next = '{phase: PH_ONE, value: 8'h00, stopped: 1'b0};
                    end
                end
                PH_ONE: begin
                    if (i_last) begin
                        w_emit = 1'b1;
                        w_val  = w_dig.value;
                    end else begin
                        o_esc_next       = w_dig;
                        o_esc_next.phase = PH_TWO;
                    end
                end
                default: begin
                    // Second escape byte closes the escape
                    w_emit = 1'b1;
                    w_val  = w_dig.value;
                end
            endcase

            // Emit the decoded value, zero as a space, and clear the escape
            if (w_emit) begin
                o_cnt      = 2'd1;
                o_res[0]   = '{data: (w_val == 8'h00) ? CHAR_SPACE : w_val,
                               run_end: 1'b1, string_end: i_last};
                o_esc_next = ESC_CLEAR;
            end
        end
    end

endmodule

// ----- hw/rtl/url_percent_codec.sv -----
// ----------------------------------------------------------------------------
// url_percent_codec
// An accepted byte is held in the input stage, its words in the result stage.
// Throughput: one byte per cycle for pass-through and decode unless the output
// stalls; an encoded escape sends three words through the single output port.
// Reset (synchronous, active low): mode encode, escape state clear, input
// and output stages empty.
// ----------------------------------------------------------------------------
module url_percent_codec import upc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_run_end,
    output logic                 o_string_end
);

    logic       r_mode;
    t_esc       r_esc;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic [1:0] r_cnt;
    t_res_set   r_res;

    logic       w_cfg_wr;
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_move;
    logic [1:0] w_cnt;
    t_res_set   w_res;
    t_esc       w_esc_next;

    // Configuration access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == ADDR_MODE);
    assign prdata   = (paddr == ADDR_MODE) ? {31'h0, r_mode} : 32'h0;

    // Handshakes: load the result stage when it is empty or its last word leaves
    assign o_out_valid = (r_cnt != 2'd0);
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign w_move      = r_in_valid &&
                         ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_out_acc));
    assign o_in_stall  = r_in_valid && !w_move;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    assign o_out_byte   = r_res[0].data;
    assign o_run_end    = r_res[0].run_end;
    assign o_string_end = r_res[0].string_end;

    upc_step u_step (
        .i_mode     (r_mode),
        .i_esc      (r_esc),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .o_cnt      (w_cnt),
        .o_res      (w_res),
        .o_esc_next (w_esc_next)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ENCODE;
            r_esc      <= ESC_CLEAR;
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (w_cfg_wr) begin
                r_mode <= pwdata[0];
                r_esc  <= ESC_CLEAR;
            end else if (w_move) begin
                r_esc <= w_esc_next;
            end

            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end

            if (w_move) begin
                r_cnt <= w_cnt;
            end else if (w_out_acc) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Payload: hold the input byte, load or advance the result words
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
        if (w_move) begin
            r_res <= w_res;
        end else if (w_out_acc) begin
            r_res <= {r_res[2], r_res[2], r_res[1]};
        end
    end

`ifndef SYNTHESIS
    a_encode_no_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ENCODE) |-> (r_esc.phase == PH_IDLE))
        else $error("escape open in encode mode");

    a_stopped_in_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc.stopped |-> (r_esc.phase != PH_IDLE))
        else $error("frozen escape value outside an escape");

    a_final_word_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_cnt == 2'd1)) |-> o_run_end)
        else $error("final buffered word lacks run end");

    a_string_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_string_end) |-> o_run_end)
        else $error("string end without run end");

    a_cfg_clears_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_esc == ESC_CLEAR))
        else $error("mode write left escape state");
`endif

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb - URL percent codec testbench
// Drives character strings into the codec in both directions and compares
// every output word with a predictor kept inside the bench. A short directed
// part covers the boundary bytes, encoding of unsafe characters and the
// decode corner cases: frozen escapes, zero values, strings that end inside
// an escape, and a mode write in the middle of an escape. Random phases
// alternate the mode while the sender idles in bursts and the receiver
// stalls, including one long hold-off that backs the codec up.
// ----------------------------------------------------------------------------
module tb import upc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    IDLE_LIMIT   = 2000;
    localparam int    DRAIN_CYCLES = 8;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    HOLD_AFTER   = 150;
    localparam string SAFE_PUNCT   = ":@&=+$-_.!*'(),/?~";
    localparam string HEX_DIGITS   = "0123456789abcdef";

    typedef struct packed {
        logic [7:0] chr;
        logic       last;
    } t_char_item;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} t_stall_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_in_byte = 8'h00;
    logic                 i_in_last = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_run_end;
    logic                 o_string_end;

    // Characters waiting to be sent and words the codec still owes us
    t_char_item pending_chars[$];
    t_res       expected_words[$];
    t_char_item next_char;

    // Predictor state
    logic       cur_mode = MODE_ENCODE;
    t_phase     esc_phase = PH_IDLE;
    logic [7:0] esc_value = 8'h00;
    logic       esc_frozen = 1'b0;

    // Sender and receiver pacing
    int           burst_left = 1;
    int           gap_left = 0;
    int           style_left = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    t_stall_style stall_style = STALL_NONE;

    // Bookkeeping
    int fail_count = 0;
    int words_checked = 0;
    int encode_chars = 0;
    int decode_chars = 0;
    int mode_writes = 0;

    url_percent_codec u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end),
        .o_string_end (o_string_end)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Letters, digits and the fixed punctuation set travel unencoded
    function automatic logic char_is_safe(input logic [7:0] c);
        logic ok;
        ok = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
        for (int i = 0; i < SAFE_PUNCT.len(); i++) begin
            if (SAFE_PUNCT[i] == c) begin
                ok = 1'b1;
            end
        end
        return ok;
    endfunction

    // Hex digit value of either case, -1 when the byte is not a hex digit
    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return c - "0";
        end
        if (c >= "a" && c <= "f") begin
            return c - "a" + 10;
        end
        if (c >= "A" && c <= "F") begin
            return c - "A" + 10;
        end
        return -1;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        logic [7:0] c;
        c = HEX_DIGITS[$urandom_range(0, 15)];
        // Upper case for the letters half of the time
        if (c >= "a" && $urandom_range(0, 1)) begin
            c = c - 8'h20;
        end
        return c;
    endfunction

    task automatic push_word(input logic [7:0] data, input logic run_end, input logic str_end);
        expected_words.push_back('{data: data, run_end: run_end, string_end: str_end});
    endtask

    task automatic clear_escape();
        esc_phase  = PH_IDLE;
        esc_value  = 8'h00;
        esc_frozen = 1'b0;
    endtask

    // Shift a digit into the escape value until a non-hex byte freezes it
    task automatic fold_digit(input logic [7:0] c);
        int d;
        d = hex_digit_value(c);
        if (!esc_frozen) begin
            if (d < 0) begin
                esc_frozen = 1'b1;
            end else begin
                esc_value = {esc_value[3:0], 4'(d)};
            end
        end
    endtask

    // Work out the words one accepted character produces
    task automatic codec_predict(input logic [7:0] c, input logic last);
        logic emit;
        emit = 1'b0;
        if (cur_mode == MODE_ENCODE) begin
            if (char_is_safe(c)) begin
                push_word(c, 1'b1, last);
            end else begin
                push_word(CHAR_PERCENT, 1'b0, 1'b0);
                push_word(HEX_DIGITS[c[7:4]], 1'b0, 1'b0);
                push_word(HEX_DIGITS[c[3:0]], 1'b1, last);
            end
        end else begin
            case (esc_phase)
                PH_IDLE: begin
                    if (c != CHAR_PERCENT) begin
                        push_word(c, 1'b1, last);
                    end else begin
                        clear_escape();
                        esc_phase = PH_ONE;
                        emit = last;
                    end
                end
                PH_ONE: begin
                    fold_digit(c);
                    esc_phase = PH_TWO;
                    emit = last;
                end
                default: begin
                    fold_digit(c);
                    emit = 1'b1;
                end
            endcase
            // Close the escape, or cut it short at the end of the string
            if (emit) begin
                push_word((esc_value == 8'h00) ? CHAR_SPACE : esc_value, 1'b1, last);
                clear_escape();
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("word %0d: %s is 0x%0h, expected 0x%0h", words_checked, what, got, want);
        fail_count++;
    endtask

    task automatic add_char(input logic [7:0] c, input logic last);
        pending_chars.push_back('{chr: c, last: last});
    endtask

    // Queue a string, marking its final character as the end if asked
    task automatic add_text(input string s, input logic end_string);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i], end_string && (i == s.len() - 1));
        end
    endtask

    // Write the mode register through a setup and an access cycle
    task automatic write_mode(input logic m);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODE;
        pwdata  <= 32'(m);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_mode = m;
        clear_escape();
        mode_writes++;
        @(negedge i_clk);
    endtask

    // Wait until every character is in and every word is out, then drain
    task automatic settle_codec();
        while (pending_chars.size() != 0 || i_in_valid || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sender: predict on acceptance, then offer the next character in bursts
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            codec_predict(i_in_byte, i_in_last);
            if (cur_mode == MODE_ENCODE) begin
                encode_chars++;
            end else begin
                decode_chars++;
            end
        end
        if (!i_in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (pending_chars.size() != 0) begin
                next_char = pending_chars.pop_front();
                i_in_valid <= 1'b1;
                i_in_byte  <= next_char.chr;
                i_in_last  <= next_char.last;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a changing pattern, with one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && words_checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (style_left == 0) begin
                stall_style = t_stall_style'($urandom_range(0, 3));
                style_left  = $urandom_range(8, 64);
            end else begin
                style_left--;
            end
            case (stall_style)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HALF:  i_out_stall <= ($urandom_range(0, 1) == 0);
                default:     i_out_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Monitor: compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word, out_byte", o_out_byte, 0);
            end else begin
                want = expected_words.pop_front();
                if (o_out_byte !== want.data) begin
                    report_mismatch("out_byte", o_out_byte, want.data);
                end
                if (o_run_end !== want.run_end) begin
                    report_mismatch("run_end", o_run_end, want.run_end);
                end
                if (o_string_end !== want.string_end) begin
                    report_mismatch("string_end", o_string_end, want.string_end);
                end
            end
            words_checked++;
        end
    end

    // Watchdog: give up when nothing has moved for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int         n;
        int         pick;
        logic [7:0] c;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Encode: boundary bytes, high bytes, safe characters, end of string
        write_mode(MODE_ENCODE);
        add_char(8'h01, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(8'h80, 1'b0);
        add_text("aZ9~", 1'b0);
        add_text("%", 1'b1);
        settle_codec();

        // Decode: a full escape, frozen escapes, zero as space,
        // strings cut inside an escape, and one escape left open
        write_mode(MODE_DECODE);
        add_text("%41%g1%Az", 1'b0);
        add_char(8'hFF, 1'b1);
        add_text("%", 1'b1);
        add_text("%f", 1'b1);
        add_text("%4", 1'b0);
        settle_codec();

        // Rewrite the mode mid-escape; the next byte must pass straight through
        write_mode(MODE_DECODE);
        add_text("q", 1'b1);

        // Random phases with alternating direction
        for (int p = 0; p < 8; p++) begin
            settle_codec();
            write_mode((p % 2 == 0) ? MODE_ENCODE : MODE_DECODE);
            n = 0;
            while (n < 35) begin
                if (cur_mode == MODE_ENCODE) begin
                    c = $urandom_range(0, 1) ? 8'($urandom_range(1, 255))
                                             : 8'($urandom_range(8'h20, 8'h7E));
                    add_char(c, $urandom_range(0, 7) == 0);
                    n++;
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6) begin
                        // Well-formed escape with random digits
                        add_char(CHAR_PERCENT, 1'b0);
                        add_char(rand_hex_char(), 1'b0);
                        add_char(rand_hex_char(), $urandom_range(0, 5) == 0);
                        n += 3;
                    end else if (pick == 6) begin
                        // Broken escape, possibly cut short
                        add_char(CHAR_PERCENT, $urandom_range(0, 5) == 0);
                        add_char(8'($urandom_range(1, 255)), $urandom_range(0, 5) == 0);
                        add_char(8'($urandom_range(1, 255)), $urandom_range(0, 5) == 0);
                        n += 3;
                    end else begin
                        add_char(8'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
                        n++;
                    end
                end
            end
        end
        settle_codec();

        $display("Sent %0d characters to encode and %0d to decode, checked %0d words,",
                 encode_chars, decode_chars, words_checked);
        $display("across %0d mode writes and one long output hold-off.", mode_writes);
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/upc_pkg.sv
hw/rtl/upc_step.sv
hw/rtl/url_percent_codec.sv
test/tb.sv
